### rtl/trtm_pkg.sv
`timescale 1ns / 1ps
package trtm_pkg;
	localparam logic [15:0] T_SYN = 16'd0;
	localparam logic [15:0] T_KEY = 16'd1;
	localparam logic [15:0] T_ABS = 16'd3;
	localparam logic [15:0] C_ABS_X = 16'h00;
	localparam logic [15:0] C_ABS_Y = 16'h01;
	localparam logic [15:0] C_MT_SLOT = 16'h2f;
	localparam logic [15:0] C_MT_POS_X = 16'h35;
	localparam logic [15:0] C_MT_POS_Y = 16'h36;
	localparam logic [15:0] C_MT_TRACK = 16'h39;
	localparam int EV_W = 64;
	localparam logic [2:0] REG_LEFT = 3'd0;
	localparam logic [2:0] REG_RIGHT = 3'd1;
	localparam logic [2:0] REG_TOP = 3'd2;
	localparam logic [2:0] REG_BOTTOM = 3'd3;
	localparam logic [2:0] REG_KEY = 3'd4;

	function automatic logic [15:0] tap_code(input logic [4:0] n);
		unique case (n)
			5'd1: tap_code = 16'h145;
			5'd2: tap_code = 16'h14d;
			5'd3: tap_code = 16'h14e;
			5'd4: tap_code = 16'h14f;
			5'd5: tap_code = 16'h148;
			default: tap_code = 16'h0;
		endcase
	endfunction

	function automatic logic is_x(input logic [15:0] t, input logic [15:0] c);
		is_x = (t == T_ABS) && (c == C_ABS_X || c == C_MT_POS_X);
	endfunction

	function automatic logic is_y(input logic [15:0] t, input logic [15:0] c);
		is_y = (t == T_ABS) && (c == C_ABS_Y || c == C_MT_POS_Y);
	endfunction
endpackage

### rtl/trtm_ram.sv
`timescale 1ns / 1ps
module trtm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/touch_region_trackpad_mapper_core.sv
`timescale 1ns / 1ps
// non-sync request: stored in the event memory unless the memory is full
// sync report: a scan of the SLOT_COUNT slot ids, two multitap steps, a search for the latest x/y
// and a decide step, then the results as the output register frees up, then the closing sync
// one request at a time; a new request is taken once the closing sync sits in the output register
// reset clears control state, slot ids to -1, registers to their reset values; memory is not cleared
module touch_region_trackpad_mapper_core
	import trtm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 24,
	parameter int SLOT_COUNT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata, // ev_type, ev_code, ev_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata, // out_type, out_code, out_value
	output logic        m_tuser, // out_device
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int FW = $clog2(SLOT_COUNT + 1);

	typedef enum logic [3:0] {
		IDLE, SCAN, TAP_OLD, TAP_NEW, FIND, DECIDE, SIDE_K, SIDE_S,
		REL_K, REL_S, EMIT, SYNC
	} state_t;

	state_t state_q;
	logic [15:0] left_q, top_q;
	logic [16:0] right_q, bottom_q;
	logic [9:0]  key_q;
	logic [31:0] ids_q [SLOT_COUNT];
	logic [31:0] slot_q;
	logic [CW-1:0] count_q, idx_q;
	logic [FW-1:0] fingers_q, newcnt_q;
	logic [SW-1:0] sidx_q;
	logic signed [31:0] lx_q, ly_q, x_q, y_q, cx_q, cy_q, syncv_q;
	logic side_q, sideval_q, pt_ok_q;
	logic [15:0] tapold_q;
	logic tapnew_q;
	logic fwd_q;
	logic [63:0] fwdata_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0] wdata, rdata, rd;

	trtm_ram #(.WIDTH(EV_W), .DEPTH(QUEUE_DEPTH)) u_buf (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// write in the same cycle as a read of that entry
	assign rd = fwd_q ? fwdata_q : rdata;

	logic [15:0] in_type, in_code, r_type, r_code;
	logic signed [31:0] in_val, r_val;
	assign in_type = s_tdata[15:0];
	assign in_code = s_tdata[31:16];
	assign in_val = s_tdata[63:32];
	assign r_type = rd[15:0];
	assign r_code = rd[31:16];
	assign r_val = rd[63:32];

	logic out_free, s_acc, is_sync, full;
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign is_sync = (in_type == T_SYN) && (in_code == 16'd0);
	assign full = (count_q >= CW'(QUEUE_DEPTH));

	logic tap_en;
	logic [CW-1:0] wptr;
	logic [15:0] tcode;
	// memory write: input events and multitap keys
	always_comb begin
		tcode = tap_code(5'(fingers_q));
		wptr = count_q;
		we = 1'b0;
		wdata = {in_val, in_code, in_type};
		if (state_q == IDLE) begin
			we = s_acc && !is_sync && !full;
		end else if (state_q == TAP_OLD) begin
			we = !full && tapold_q != 16'd0 && newcnt_q != fingers_q;
			wdata = {32'sd0, tapold_q, T_KEY};
		end else if (state_q == TAP_NEW) begin
			we = !full && tapnew_q && tcode != 16'd0;
			wdata = {32'sd1, tcode, T_KEY};
		end
		tap_en = we;
		waddr = wptr[AW-1:0];
	end

	// clamp
	logic signed [33:0] xs, ys, lo_x, hi_x, lo_y, hi_y, ccx, ccy;
	always_comb begin
		xs = 34'(x_q);
		ys = 34'(y_q);
		lo_x = {18'd0, left_q};
		hi_x = {17'd0, right_q};
		lo_y = {18'd0, top_q};
		hi_y = {17'd0, bottom_q};
		if (xs < lo_x) ccx = lo_x;
		else if (xs >= hi_x) ccx = hi_x - 34'sd1;
		else ccx = xs;
		if (ys < lo_y) ccy = lo_y;
		else if (ys >= hi_y) ccy = hi_y - 34'sd1;
		else ccy = ys;
		ccx = ccx - lo_x;
		ccy = ccy - lo_y;
	end
	logic side_now;
	assign side_now = (ys >= lo_y) && (ys < hi_y) && ((xs < lo_x) || (xs >= hi_x));

	logic [CW-1:0] ridx;
	always_comb begin
		ridx = idx_q;
		if (state_q == DECIDE || state_q == SIDE_K || state_q == SIDE_S
			|| state_q == REL_K || state_q == REL_S || state_q == TAP_NEW) begin
			ridx = '0;
		end else if ((state_q == FIND) || (state_q == EMIT && out_free)) begin
			ridx = idx_q + CW'(1);
		end
		raddr = (ridx >= CW'(QUEUE_DEPTH)) ? '0 : ridx[AW-1:0];
	end

	// output register gets a new result this cycle
	logic out_load;
	assign out_load = out_free && ((state_q == SIDE_K) || (state_q == SIDE_S)
		|| (state_q == REL_S) || (state_q == SYNC)
		|| (state_q == REL_K && fingers_q == '0 && side_q && key_q != '0)
		|| (state_q == EMIT && idx_q < count_q));

	logic pw;
	assign pw = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[4:2])
			REG_LEFT: prdata = {16'd0, left_q};
			REG_RIGHT: prdata = {15'd0, right_q};
			REG_TOP: prdata = {16'd0, top_q};
			REG_BOTTOM: prdata = {15'd0, bottom_q};
			REG_KEY: prdata = {22'd0, key_q};
			default: prdata = '0;
		endcase
	end

	logic [SW-1:0] in_slot;
	assign in_slot = slot_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			left_q <= '0; right_q <= 17'h10000; top_q <= '0; bottom_q <= 17'h10000;
			key_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) ids_q[i] <= '1;
			slot_q <= '0; count_q <= '0; idx_q <= '0; fingers_q <= '0; newcnt_q <= '0;
			sidx_q <= '0; lx_q <= '0; ly_q <= '0; x_q <= '0; y_q <= '0;
			cx_q <= '0; cy_q <= '0; syncv_q <= '0; side_q <= 1'b0; sideval_q <= 1'b0;
			pt_ok_q <= 1'b0; tapold_q <= '0; tapnew_q <= 1'b0;
			fwd_q <= 1'b0; fwdata_q <= '0;
			m_tvalid <= 1'b0; m_tdata <= '0; m_tuser <= 1'b0; m_tlast <= 1'b0;
		end else begin
			if (pw) begin
				unique case (paddr[4:2])
					REG_LEFT: left_q <= pwdata[15:0];
					REG_RIGHT: right_q <= pwdata[16:0];
					REG_TOP: top_q <= pwdata[15:0];
					REG_BOTTOM: bottom_q <= pwdata[16:0];
					REG_KEY: key_q <= pwdata[9:0];
					default: ;
				endcase
			end
			fwd_q <= we && (waddr == raddr);
			fwdata_q <= wdata;
			if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
			if (tap_en) count_q <= count_q + CW'(1);
			unique case (state_q)
				IDLE: if (s_acc) begin
					if (is_sync) begin
						syncv_q <= in_val;
						newcnt_q <= '0;
						sidx_q <= '0;
						state_q <= SCAN;
					end else begin
						if (in_type == T_ABS && in_code == C_MT_SLOT) slot_q <= in_val;
						else if (in_type == T_ABS && in_code == C_MT_TRACK
							&& slot_q < 32'(SLOT_COUNT)) ids_q[in_slot] <= in_val;
					end
				end
				SCAN: begin
					if ($signed(ids_q[sidx_q]) > 0) newcnt_q <= newcnt_q + FW'(1);
					if (32'(sidx_q) == 32'(SLOT_COUNT - 1)) state_q <= TAP_OLD;
					else sidx_q <= sidx_q + SW'(1);
					tapold_q <= tap_code(5'(fingers_q));
				end
				TAP_OLD: begin
					state_q <= TAP_NEW;
					tapnew_q <= (newcnt_q != fingers_q);
					if (newcnt_q != fingers_q) fingers_q <= newcnt_q;
				end
				TAP_NEW: begin
					// only the new-count tap when the count changed
					idx_q <= '0;
					x_q <= lx_q; y_q <= ly_q;
					state_q <= FIND;
				end
				FIND: begin
					if (idx_q < count_q) begin
						if (is_x(r_type, r_code)) x_q <= r_val;
						else if (is_y(r_type, r_code)) y_q <= r_val;
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= DECIDE;
					end
				end
				DECIDE: begin
					idx_q <= '0;
					pt_ok_q <= (x_q != -32'sd1) && (y_q != -32'sd1);
					cx_q <= ccx[31:0];
					cy_q <= ccy[31:0];
					if (x_q != -32'sd1 && y_q != -32'sd1) begin
						lx_q <= x_q; ly_q <= y_q;
						if (side_now != side_q) begin
							side_q <= side_now;
							sideval_q <= side_now;
							state_q <= (key_q != '0) ? SIDE_K : REL_K;
						end else state_q <= REL_K;
					end else state_q <= REL_K;
				end
				SIDE_K: if (out_free) begin
					m_tvalid <= 1'b1; m_tuser <= 1'b1; m_tlast <= 1'b0;
					m_tdata <= {{31'd0, sideval_q}, 6'd0, key_q, T_KEY};
					state_q <= SIDE_S;
				end
				SIDE_S: if (out_free) begin
					m_tvalid <= 1'b1; m_tuser <= 1'b1; m_tlast <= 1'b0;
					m_tdata <= {32'd0, 16'd0, T_SYN};
					state_q <= REL_K;
				end
				REL_K: begin
					if (fingers_q == '0 && side_q) begin
						if (key_q != '0) begin
							if (out_free) begin
								side_q <= 1'b0;
								m_tvalid <= 1'b1; m_tuser <= 1'b1; m_tlast <= 1'b0;
								m_tdata <= {32'd0, 6'd0, key_q, T_KEY};
								state_q <= REL_S;
							end
						end else begin
							side_q <= 1'b0;
							state_q <= EMIT;
						end
					end else state_q <= EMIT;
				end
				REL_S: if (out_free) begin
					m_tvalid <= 1'b1; m_tuser <= 1'b1; m_tlast <= 1'b0;
					m_tdata <= {32'd0, 16'd0, T_SYN};
					state_q <= EMIT;
				end
				EMIT: if (out_free) begin
					if (idx_q < count_q) begin
						m_tvalid <= 1'b1; m_tuser <= 1'b0; m_tlast <= 1'b0;
						if (pt_ok_q && is_x(r_type, r_code))
							m_tdata <= {cx_q, r_code, r_type};
						else if (pt_ok_q && is_y(r_type, r_code))
							m_tdata <= {cy_q, r_code, r_type};
						else m_tdata <= rd;
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= SYNC;
					end
				end
				SYNC: if (out_free) begin
					m_tvalid <= 1'b1; m_tuser <= 1'b0; m_tlast <= 1'b1;
					m_tdata <= {syncv_q, 16'd0, T_SYN};
					count_q <= '0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

### rtl/trtm_checker.sv
`timescale 1ns / 1ps
module trtm_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast,
	input logic pready
);
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_nobusy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready) else $error("request taken mid report");
endmodule

bind touch_region_trackpad_mapper_core trtm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .pready(pready)
);

### verif/tb_touch_region_trackpad_mapper_core.sv
`timescale 1ns / 1ps
module tb_touch_region_trackpad_mapper_core;
	import trtm_pkg::*;

	localparam int DEPTH = 24;
	localparam int SLOTS = 10;

	typedef struct packed {
		logic [15:0] ev_type;
		logic [15:0] ev_code;
		logic [31:0] ev_value;
	} touch_ev_t;

	typedef struct packed {
		logic        device;
		logic [15:0] ev_type;
		logic [15:0] ev_code;
		logic [31:0] ev_value;
		logic        last;
	} mapped_ev_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	touch_region_trackpad_mapper_core dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] left_x, right_x, top_y, bottom_y, key_code;
	touch_ev_t held_ev[DEPTH];
	int held_count;
	logic signed [31:0] slot_id[SLOTS];
	logic [31:0] cur_slot;
	int fingers;
	logic signed [31:0] prev_x, prev_y;
	logic side_on;

	touch_ev_t pending_reqs[$];
	mapped_ev_t expected_evs[$];
	int errors = 0;
	bit feeding_done = 0;

	function automatic logic [15:0] tap_key(int n);
		case (n)
			1: return 16'h145;
			2: return 16'h14d;
			3: return 16'h14e;
			4: return 16'h14f;
			5: return 16'h148;
			default: return 16'h0;
		endcase
	endfunction

	function automatic bit x_ev(touch_ev_t e);
		return e.ev_type == T_ABS && (e.ev_code == C_ABS_X || e.ev_code == C_MT_POS_X);
	endfunction

	function automatic bit y_ev(touch_ev_t e);
		return e.ev_type == T_ABS && (e.ev_code == C_ABS_Y || e.ev_code == C_MT_POS_Y);
	endfunction

	task automatic hold_ev(logic [15:0] t, logic [15:0] c, logic [31:0] v);
		if (held_count < DEPTH) begin
			held_ev[held_count] = '{t, c, v};
			held_count++;
		end
	endtask

	task automatic emit(logic d, logic [15:0] t, logic [15:0] c, logic [31:0] v, logic l);
		expected_evs.push_back('{d, t, c, v, l});
	endtask

	task automatic predict_report(touch_ev_t e);
		int cnt;
		logic signed [31:0] x, y;
		longint cx, cy;
		logic side;
		cnt = 0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_id[i] > 0) cnt++;
		if (cnt != fingers) begin
			if (fingers >= 1 && fingers <= 5) hold_ev(T_KEY, tap_key(fingers), 0);
			if (cnt >= 1 && cnt <= 5) hold_ev(T_KEY, tap_key(cnt), 1);
			fingers = cnt;
		end
		x = prev_x;
		y = prev_y;
		for (int i = 0; i < held_count; i++)
			if (x_ev(held_ev[i])) x = held_ev[i].ev_value;
			else if (y_ev(held_ev[i])) y = held_ev[i].ev_value;
		if (x != -1 && y != -1) begin
			side = 0;
			if (longint'(y) >= longint'(top_y) && longint'(y) < longint'(bottom_y))
				if (longint'(x) < longint'(left_x) || longint'(x) >= longint'(right_x))
					side = 1;
			if (side != side_on) begin
				side_on = side;
				if (key_code != 0) begin
					emit(1, T_KEY, key_code[15:0], {31'b0, side}, 0);
					emit(1, T_SYN, 16'h0, 0, 0);
				end
			end
			prev_x = x;
			prev_y = y;
			cx = x;
			cy = y;
			if (cx < longint'(left_x)) cx = left_x;
			else if (cx >= longint'(right_x)) cx = longint'(right_x) - 1;
			if (cy < longint'(top_y)) cy = top_y;
			else if (cy >= longint'(bottom_y)) cy = longint'(bottom_y) - 1;
			cx -= longint'(left_x);
			cy -= longint'(top_y);
			for (int i = 0; i < held_count; i++)
				if (x_ev(held_ev[i])) held_ev[i].ev_value = cx[31:0];
				else if (y_ev(held_ev[i])) held_ev[i].ev_value = cy[31:0];
		end
		if (cnt == 0 && side_on) begin
			side_on = 0;
			if (key_code != 0) begin
				emit(1, T_KEY, key_code[15:0], 0, 0);
				emit(1, T_SYN, 16'h0, 0, 0);
			end
		end
		for (int i = 0; i < held_count; i++)
			emit(0, held_ev[i].ev_type, held_ev[i].ev_code, held_ev[i].ev_value, 0);
		held_count = 0;
		emit(0, T_SYN, 16'h0, e.ev_value, 1);
	endtask

	task automatic predict_request(touch_ev_t e);
		if (e.ev_type == T_SYN && e.ev_code == 0) begin
			predict_report(e);
		end else begin
			if (e.ev_type == T_ABS) begin
				if (e.ev_code == C_MT_SLOT) cur_slot = e.ev_value;
				else if (e.ev_code == C_MT_TRACK && cur_slot < SLOTS)
					slot_id[cur_slot] = e.ev_value;
			end
			hold_ev(e.ev_type, e.ev_code, e.ev_value);
		end
	endtask

	// driver
	int gap = 0;
	logic s_tready_seen = 0;
	always @(posedge clk) s_tready_seen <= s_tvalid && s_tready;

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) predict_request(pending_reqs.pop_front());
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 0;
		end else if (!s_tvalid || s_tready_seen) begin
			if (pending_reqs.size() > 0 && gap == 0) begin
				s_tvalid <= 1;
				s_tdata <= {pending_reqs[0].ev_value, pending_reqs[0].ev_code,
					pending_reqs[0].ev_type};
				gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
			end else begin
				s_tvalid <= 0;
				if (gap > 0) gap <= gap - 1;
			end
		end
	end

	// monitor
	int stall = 0;
	always @(posedge clk) begin
		mapped_ev_t want;
		if (m_tvalid && m_tready) begin
			if (expected_evs.size() == 0) begin
				$error("unexpected output %h dev %b last %b", m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				want = expected_evs.pop_front();
				if (m_tuser !== want.device) begin
					$error("out_device exp %0d got %0d", want.device, m_tuser);
					errors++;
				end
				if (m_tdata[15:0] !== want.ev_type) begin
					$error("out_type exp %h got %h", want.ev_type, m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] !== want.ev_code) begin
					$error("out_code exp %h got %h", want.ev_code, m_tdata[31:16]);
					errors++;
				end
				if (m_tdata[63:32] !== want.ev_value) begin
					$error("out_value exp %h got %h", want.ev_value, m_tdata[63:32]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last exp %0d got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall > 0) begin
			m_tready <= 0;
			stall <= stall - 1;
		end else begin
			m_tready <= 1;
			if (m_tvalid && m_tready)
				stall <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		case (idx)
			REG_LEFT: left_x = val[15:0];
			REG_RIGHT: right_x = val[16:0];
			REG_TOP: top_y = val[15:0];
			REG_BOTTOM: bottom_y = val[16:0];
			REG_KEY: key_code = val[9:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic quiesce();
		wait (pending_reqs.size() == 0 && !s_tvalid);
		wait (expected_evs.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic push(logic [15:0] t, logic [15:0] c, logic [31:0] v);
		pending_reqs.push_back('{t, c, v});
	endtask

	function automatic logic [31:0] coord();
		case ($urandom_range(0, 9))
			0: return 32'hffffffff;
			1: return $urandom();
			2: return $urandom_range(65530, 70000);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// one well-formed frame with random content
	task automatic random_frame();
		int n;
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: push(T_ABS, C_MT_SLOT, $urandom_range(0, 11));
				2, 3: push(T_ABS, C_MT_TRACK, $urandom_range(0, 3) == 0 ?
					32'hffffffff : $urandom_range(0, 200));
				4: push(T_ABS, C_MT_POS_X, coord());
				5: push(T_ABS, C_MT_POS_Y, coord());
				6: push(T_ABS, $urandom_range(0, 1) ? C_ABS_X : C_ABS_Y, coord());
				7: push(16'($urandom()), 16'($urandom()), $urandom());
				8: push(T_SYN, 16'($urandom_range(1, 65535)), $urandom());
				default: push(T_KEY, 16'($urandom_range(0, 767)), $urandom_range(0, 1));
			endcase
		end
		push(T_SYN, 16'h0, $urandom());
	endtask

	initial begin
		left_x = 0;
		right_x = 65536;
		top_y = 0;
		bottom_y = 65536;
		key_code = 0;
		held_count = 0;
		for (int i = 0; i < SLOTS; i++) slot_id[i] = -1;
		cur_slot = 0;
		fingers = 0;
		prev_x = 0;
		prev_y = 0;
		side_on = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed
		push(T_SYN, 16'h0, 32'h7fffffff);
		push(T_ABS, C_MT_SLOT, 0);
		push(T_ABS, C_MT_TRACK, 5);
		push(T_ABS, C_MT_POS_X, 32'h80000000);
		push(T_ABS, C_MT_POS_Y, 32'h7fffffff);
		push(T_SYN, 16'h0, 32'h80000000);
		push(T_ABS, C_MT_SLOT, 32'hffffffff);
		push(T_ABS, C_MT_TRACK, 9);
		push(T_SYN, 16'hffff, 32'h1234);
		push(16'hffff, 16'hffff, 32'hffffffff);
		push(T_ABS, C_ABS_X, 32'hffffffff);
		push(T_SYN, 16'h0, 0);
		for (int i = 0; i < 26; i++) push(T_KEY, 16'h110, i);
		push(T_SYN, 16'h0, 1);
		quiesce();

		reg_write(REG_LEFT, 32'hffff);
		reg_write(REG_RIGHT, 32'h10000);
		reg_write(REG_TOP, 100);
		reg_write(REG_BOTTOM, 60000);
		reg_write(REG_KEY, 767);
		for (int s = 1; s <= 6; s++) begin
			push(T_ABS, C_MT_SLOT, s);
			push(T_ABS, C_MT_TRACK, s);
			push(T_ABS, C_MT_POS_X, 5);
			push(T_ABS, C_MT_POS_Y, 500);
			push(T_SYN, 16'h0, s);
		end
		for (int s = 0; s <= 6; s++) begin
			push(T_ABS, C_MT_SLOT, s);
			push(T_ABS, C_MT_TRACK, 32'hffffffff);
		end
		push(T_SYN, 16'h0, 0);
		quiesce();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_LEFT, 1000);
					reg_write(REG_RIGHT, 50000);
					reg_write(REG_TOP, 2000);
					reg_write(REG_BOTTOM, 40000);
					reg_write(REG_KEY, 30);
				end
				1: begin
					reg_write(REG_LEFT, 40000);
					reg_write(REG_RIGHT, 1);
					reg_write(REG_TOP, 65535);
					reg_write(REG_BOTTOM, 1);
					reg_write(REG_KEY, 0);
				end
				2: begin
					reg_write(REG_LEFT, 0);
					reg_write(REG_RIGHT, 65536);
					reg_write(REG_TOP, 0);
					reg_write(REG_BOTTOM, 65536);
					reg_write(REG_KEY, 512);
				end
				default: begin
					reg_write(REG_LEFT, $urandom_range(0, 65535));
					reg_write(REG_RIGHT, $urandom_range(1, 65536));
					reg_write(REG_TOP, $urandom_range(0, 65535));
					reg_write(REG_BOTTOM, $urandom_range(1, 65536));
					reg_write(REG_KEY, $urandom_range(0, 767));
				end
			endcase
			for (int f = 0; f < 12; f++) random_frame();
			quiesce();
		end
		feeding_done = 1;
	end

	initial begin
		wait (feeding_done);
		if (errors == 0)
			$display("PASS touch_region_trackpad_mapper_core");
		else
			$display("FAIL touch_region_trackpad_mapper_core");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL touch_region_trackpad_mapper_core");
		$finish;
	end
endmodule

### filelist.f
rtl/trtm_pkg.sv
rtl/trtm_ram.sv
rtl/touch_region_trackpad_mapper_core.sv
rtl/trtm_checker.sv
verif/tb_touch_region_trackpad_mapper_core.sv
